[rtl/fct_pkg.sv]
package fct_pkg;
  localparam int NUM_PLANES = 6;
  localparam int NUM_REGS = 6;
  localparam int CW = 17;
  localparam int DW = 40;
  localparam int ADDR_W = 6;

  localparam logic [1:0] CMD_POINT  = 2'd0;
  localparam logic [1:0] CMD_SPHERE = 2'd1;
  localparam logic [1:0] CMD_CUBE   = 2'd2;
  localparam logic [1:0] CMD_LINE   = 2'd3;

  typedef logic [63:0] plane_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } pt_t;

  // Points: 0..7 cube corners, 8 center or start, 9 line end.
  localparam int NPTS = 10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [14:0] ext;
  } ctl_t;
endpackage

[rtl/fct_dist.sv]
module fct_dist (
  input  logic clk,
  input  logic en,
  input  fct_pkg::plane_t plane,
  input  fct_pkg::pt_t pt,
  output logic signed [fct_pkg::DW-1:0] dist_r
);
  import fct_pkg::*;
  logic signed [33:0] pa_r, pb_r, pc_r;
  logic signed [30:0] pd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= 34'($signed(plane[15:0]) * pt.x);
      pb_r <= 34'($signed(plane[31:16]) * pt.y);
      pc_r <= 34'($signed(plane[47:32]) * pt.z);
      // scale D up by 2^14, keeping its sign
      pd_r <= {plane[63], plane[63:48], 14'd0};
    end
  end
  always_ff @(posedge clk) begin
    if (en) dist_r <= DW'(pa_r) + DW'(pb_r) + DW'(pc_r) + DW'(pd_r);
  end
endmodule

[rtl/fct_eval.sv]
module fct_eval (
  input  fct_pkg::ctl_t ctl,
  input  logic [fct_pkg::NUM_PLANES-1:0][fct_pkg::NPTS-1:0][fct_pkg::DW-1:0] d,
  output logic res
);
  import fct_pkg::*;
  logic signed [DW-1:0] dv;
  logic signed [DW-1:0] nr;
  logic pt_ok, sp_ok, ln_ok, cr_ok, dg_ok, rj;
  logic [7:0] cor_ok;
  always_comb begin
    nr = -$signed({{(DW-29){1'b0}}, ctl.ext, 14'd0});
    pt_ok = 1'b1; sp_ok = 1'b1; ln_ok = 1'b0; dg_ok = 1'b0; rj = 1'b0;
    cor_ok = '1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      dv = $signed(d[p][8]);
      if (dv <= 0) pt_ok = 1'b0;
      if (dv <= nr) sp_ok = 1'b0;
      if (($signed(d[p][8]) < 0 && $signed(d[p][9]) > 0) ||
          ($signed(d[p][8]) > 0 && $signed(d[p][9]) < 0)) ln_ok = 1'b1;
      for (int i = 0; i < 8; i++)
        if ($signed(d[p][i]) <= 0) cor_ok[i] = 1'b0;
      if (($signed(d[p][0]) < 0 && $signed(d[p][7]) > 0) ||
          ($signed(d[p][0]) > 0 && $signed(d[p][7]) < 0) ||
          ($signed(d[p][1]) < 0 && $signed(d[p][3]) > 0) ||
          ($signed(d[p][1]) > 0 && $signed(d[p][3]) < 0) ||
          ($signed(d[p][4]) < 0 && $signed(d[p][6]) > 0) ||
          ($signed(d[p][4]) > 0 && $signed(d[p][6]) < 0)) dg_ok = 1'b1;
      begin
        logic any;
        any = $signed(d[p][8]) > 0;
        for (int i = 0; i < 8; i++) if ($signed(d[p][i]) > 0) any = 1'b1;
        if (!any) rj = 1'b1;
      end
    end
    cr_ok = (|cor_ok) | dg_ok | !rj;
    case (ctl.cmd)
      CMD_POINT:  res = pt_ok;
      CMD_SPHERE: res = sp_ok;
      CMD_CUBE:   res = cr_ok;
      default:    res = ln_ok;
    endcase
  end
endmodule

[rtl/frustum_cull_test.sv]
// Pipeline: input transaction to result through registered stages (corner
// form, multiply, sum, compare into the output register).
// Throughput: one item per cycle while the output is not stalled; sixty
// dot-product units run in parallel. Stalls freeze the whole pipeline. Reset
// (rst_n, synchronous) clears valid bits and all plane registers to zero.
module frustum_cull_test (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_cmd,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic signed [15:0] in_z_pos,
  input  logic [14:0] in_extent,
  input  logic signed [15:0] in_x_end,
  input  logic signed [15:0] in_y_end,
  input  logic signed [15:0] in_z_end,
  output logic out_valid,
  input  logic out_ready,
  output logic out_inside_res,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [fct_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  import fct_pkg::*;
  plane_t plane_r [NUM_REGS];
  logic [2:0] ridx;
  assign ridx = paddr[5:3];
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) plane_r[i] <= '0;
    end else if (psel && penable && pwrite && int'(ridx) < NUM_REGS) begin
      plane_r[ridx] <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (int'(ridx) < NUM_REGS) prdata = plane_r[ridx];
  end

  logic [3:0] v_r;
  logic en;
  assign en = !v_r[3] || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[3];
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[2:0], in_valid};
  end

  ctl_t ctl0_r, ctl1_r, ctl2_r;
  pt_t pts_r [NPTS];
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [CW-1:0] xs, xm, ys, ym, zs, zm, e;
      e = CW'(signed'({2'b00, in_extent}));
      xm = CW'(in_x_pos) - e; xs = CW'(in_x_pos) + e;
      ym = CW'(in_y_pos) - e; ys = CW'(in_y_pos) + e;
      zm = CW'(in_z_pos) - e; zs = CW'(in_z_pos) + e;
      for (int i = 0; i < 8; i++) begin
        pts_r[i].x <= i[0] ? xs : xm;
        pts_r[i].y <= i[1] ? ys : ym;
        pts_r[i].z <= i[2] ? zs : zm;
      end
      pts_r[8] <= '{CW'(in_x_pos), CW'(in_y_pos), CW'(in_z_pos)};
      pts_r[9] <= '{CW'(in_x_end), CW'(in_y_end), CW'(in_z_end)};
      ctl0_r <= '{in_cmd, in_extent};
      ctl1_r <= ctl0_r;
      ctl2_r <= ctl1_r;
    end
  end

  logic [NUM_PLANES-1:0][NPTS-1:0][DW-1:0] d;
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_p
    for (genvar k = 0; k < NPTS; k++) begin : g_k
      fct_dist u_dist (.clk(clk), .en(en), .plane(plane_r[p]), .pt(pts_r[k]),
                       .dist_r(d[p][k]));
    end
  end

  logic res;
  fct_eval u_eval (.ctl(ctl2_r), .d(d), .res(res));
  always_ff @(posedge clk) begin
    if (en) out_inside_res <= res;
  end

`ifndef NO_ASSERTIONS
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("pipeline blocked with empty output");
`endif
endmodule

[verif/frustum_cull_test_test.sv]
`timescale 1ns / 100ps

module frustum_cull_test_test;
  import fct_pkg::*;

  typedef struct {
    logic [1:0] cmd;
    logic signed [15:0] x, y, z;
    logic [14:0] ext;
    logic signed [15:0] xe, ye, ze;
  } shape_t;

  class cull_scoreboard;
    logic [63:0] planes[NUM_REGS];
    bit pending_vis[$];
    int errors;

    function new();
      foreach (planes[i]) planes[i] = '0;
      errors = 0;
    endfunction

    function longint coef(int p, int k);
      logic signed [15:0] c;
      c = planes[p][16*k +: 16];
      return longint'(c);
    endfunction

    function longint plane_dist(int p, longint x, longint y, longint z);
      return coef(p, 0) * x + coef(p, 1) * y + coef(p, 2) * z + coef(p, 3) * 16384;
    endfunction

    function bit point_vis(longint x, longint y, longint z);
      for (int p = 0; p < NUM_PLANES; p++)
        if (plane_dist(p, x, y, z) <= 0) return 0;
      return 1;
    endfunction

    function bit line_vis(longint x0, longint y0, longint z0,
                          longint x1, longint y1, longint z1);
      longint s, e;
      for (int p = 0; p < NUM_PLANES; p++) begin
        s = plane_dist(p, x0, y0, z0);
        e = plane_dist(p, x1, y1, z1);
        if ((s < 0 && e > 0) || (s > 0 && e < 0)) return 1;
      end
      return 0;
    endfunction

    function bit cube_vis(longint x, longint y, longint z, longint s);
      longint cx, cy, cz;
      bit any;
      for (int i = 0; i < 8; i++) begin
        cx = i[0] ? x + s : x - s;
        cy = i[1] ? y + s : y - s;
        cz = i[2] ? z + s : z - s;
        if (point_vis(cx, cy, cz)) return 1;
      end
      if (line_vis(x - s, y - s, z - s, x + s, y + s, z + s)) return 1;
      if (line_vis(x + s, y - s, z - s, x + s, y + s, z - s)) return 1;
      if (line_vis(x - s, y - s, z + s, x - s, y + s, z + s)) return 1;
      for (int p = 0; p < NUM_PLANES; p++) begin
        any = plane_dist(p, x, y, z) > 0;
        for (int i = 0; i < 8 && !any; i++) begin
          cx = i[0] ? x + s : x - s;
          cy = i[1] ? y + s : y - s;
          cz = i[2] ? z + s : z - s;
          if (plane_dist(p, cx, cy, cz) > 0) any = 1;
        end
        if (!any) return 0;
      end
      return 1;
    endfunction

    function void note_shape(shape_t s);
      bit v;
      longint r;
      r = longint'(s.ext);
      case (s.cmd)
        CMD_POINT: v = point_vis(s.x, s.y, s.z);
        CMD_SPHERE: begin
          v = 1;
          for (int p = 0; p < NUM_PLANES; p++)
            if (plane_dist(p, s.x, s.y, s.z) <= -(r * 16384)) v = 0;
        end
        CMD_CUBE: v = cube_vis(s.x, s.y, s.z, r);
        default: v = line_vis(s.x, s.y, s.z, s.xe, s.ye, s.ze);
      endcase
      pending_vis.push_back(v);
    endfunction

    function void check_result(logic res);
      bit v;
      if (pending_vis.size() == 0) begin
        report_mismatch("result with nothing pending", 0, res);
        return;
      end
      v = pending_vis.pop_front();
      if (res !== v) report_mismatch("inside_res", v, res);
    endfunction

    function void report_mismatch(string what, logic want, logic got);
      $display("mismatch %s: expected %0b got %0b at %0t", what, want, got, $time);
      errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_cmd;
  logic signed [15:0] in_x_pos, in_y_pos, in_z_pos, in_x_end, in_y_end, in_z_end;
  logic [14:0] in_extent;
  logic out_valid, out_ready, out_inside_res;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  cull_scoreboard board;
  int send_idle_pct, recv_idle_pct;
  bit recv_hold;
  int quiet_cycles;

  frustum_cull_test dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // watchdog and result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_inside_res);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("frustum_cull_test_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_plane(int idx, logic [63:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'(8 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx < NUM_REGS) board.planes[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_shape(shape_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_cmd <= s.cmd; in_extent <= s.ext;
    in_x_pos <= s.x; in_y_pos <= s.y; in_z_pos <= s.z;
    in_x_end <= s.xe; in_y_end <= s.ye; in_z_end <= s.ze;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_shape(s);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending_vis.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(bit near);
    if (near) return 16'($signed($urandom_range(1600)) - 800);
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic shape_t rand_shape();
    shape_t s;
    bit near;
    near = $urandom_range(3) != 0;
    s.cmd = 2'($urandom);
    s.x = rand_coord(near); s.y = rand_coord(near); s.z = rand_coord(near);
    s.xe = rand_coord(near); s.ye = rand_coord(near); s.ze = rand_coord(near);
    s.ext = near ? 15'($urandom_range(400)) : 15'($urandom);
    return s;
  endfunction

  // box-like frustum: six axis planes, coefficients +-1.0, offsets of the half size
  function automatic logic [63:0] axis_plane(int p, int half);
    logic signed [15:0] a, b, c, d;
    a = 0; b = 0; c = 0;
    case (p / 2)
      0: a = (p % 2) ? 16'sd16384 : -16'sd16384;
      1: b = (p % 2) ? 16'sd16384 : -16'sd16384;
      default: c = (p % 2) ? 16'sd16384 : -16'sd16384;
    endcase
    d = 16'(half);
    return {d, c, b, a};
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_shape(rand_shape());
  endtask

  task automatic directed();
    shape_t s;
    logic [1:0] ops[4] = '{CMD_POINT, CMD_SPHERE, CMD_CUBE, CMD_LINE};
    foreach (ops[k]) begin
      s.cmd = ops[k];
      s.x = 16'sh7fff; s.y = 16'sh8000; s.z = 0; s.ext = 15'h7fff;
      s.xe = 16'sh8000; s.ye = 16'sh7fff; s.ze = 16'shffff;
      send_shape(s);
      s.x = 0; s.y = 0; s.z = 0; s.ext = 0; s.xe = 16'sd100; s.ye = 0; s.ze = 0;
      send_shape(s);
      s.x = 16'sh8000; s.y = 16'sh8000; s.z = 16'sh8000; s.ext = 15'h7fff;
      s.xe = 16'sh7fff; s.ye = 16'sh7fff; s.ze = 16'sh7fff;
      send_shape(s);
      s.x = 16'sd50; s.y = -16'sd30; s.z = 16'sd10; s.ext = 15'd40;
      s.xe = -16'sd900; s.ye = 16'sd20; s.ze = 16'sd5;
      send_shape(s);
    end
  endtask

  initial begin
    logic [63:0] v;
    board = new();
    rst_n = 0; in_valid = 0; in_cmd = 0; in_extent = 0;
    in_x_pos = 0; in_y_pos = 0; in_z_pos = 0; in_x_end = 0; in_y_end = 0; in_z_end = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0; quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all-zero planes straight after reset
    directed();
    drain();

    for (int p = 0; p < NUM_REGS; p++) write_plane(p, axis_plane(p, 500));
    send_idle_pct = 11; recv_idle_pct = 54;
    directed();
    random_phase(110);
    drain();

    // extremes in every coefficient
    for (int p = 0; p < NUM_REGS; p++) begin
      v = (p % 2) ? 64'h7fff_7fff_7fff_7fff : 64'h8000_8000_8000_8000;
      write_plane(p, v);
    end
    send_idle_pct = 54; recv_idle_pct = 11;
    random_phase(60);
    drain();

    for (int p = 0; p < NUM_REGS; p++) write_plane(p, {$urandom, $urandom});
    random_phase(60);
    drain();

    for (int p = 0; p < NUM_REGS; p++) write_plane(p, axis_plane(p, 2000));
    send_idle_pct = 0; recv_idle_pct = 0;
    // hold the receiver off so the pipeline backs up into the input
    fork
      begin
        recv_hold = 1;
        repeat (60) @(posedge clk);
        recv_hold = 0;
      end
      random_phase(40);
    join
    random_phase(110);
    drain();

    if (board.errors == 0) $display("frustum_cull_test_test OK");
    else $display("frustum_cull_test_test NOT OK");
    $finish;
  end
endmodule

[frustum_cull_test.f]
rtl/fct_pkg.sv
rtl/fct_dist.sv
rtl/fct_eval.sv
rtl/frustum_cull_test.sv
verif/frustum_cull_test_test.sv
